// ----- rtl/dbv_pkg.sv -----
// Shared types, codes and constants of the message header validator.
`timescale 1ns / 1ps

package dbv_pkg;

    localparam int OFFSET_WIDTH_DEF = 32;
    // Wide enough for 16 + a 32-bit array length plus a 32-bit string length.
    localparam int POS_W = 34;

    typedef enum logic [3:0] {
        PH_FIXED,
        PH_CODE,
        PH_SIGLEN,
        PH_SIGBODY,
        PH_SIGNUL,
        PH_STRLEN,
        PH_STRBODY,
        PH_STRNUL,
        PH_WORD,
        PH_DONE,
        PH_ERR
    } phase_t;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_SHORT      = 4'd1,
        ERR_VERSION    = 4'd2,
        ERR_ENDIAN     = 4'd3,
        ERR_SERIAL     = 4'd4,
        ERR_OVERRUN    = 4'd5,
        ERR_BOUNDS     = 4'd6,
        ERR_SIGNATURE  = 4'd7,
        ERR_STRING     = 4'd8,
        ERR_FIELD_CODE = 4'd9,
        ERR_REQUIRED   = 4'd10,
        ERR_LOCAL      = 4'd11,
        ERR_TYPE       = 4'd12
    } err_t;

    localparam logic [7:0] FLD_PATH      = 8'd1;
    localparam logic [7:0] FLD_IFACE     = 8'd2;
    localparam logic [7:0] FLD_MEMBER    = 8'd3;
    localparam logic [7:0] FLD_ERRNAME   = 8'd4;
    localparam logic [7:0] FLD_REPLY     = 8'd5;
    localparam logic [7:0] FLD_DEST      = 8'd6;
    localparam logic [7:0] FLD_SENDER    = 8'd7;
    localparam logic [7:0] FLD_SIGNATURE = 8'd8;
    localparam logic [7:0] FLD_UNIX_FDS  = 8'd9;

    localparam logic [7:0] MT_CALL   = 8'd1;
    localparam logic [7:0] MT_RETURN = 8'd2;
    localparam logic [7:0] MT_ERROR  = 8'd3;
    localparam logic [7:0] MT_SIGNAL = 8'd4;

    localparam logic [7:0] CH_BIG      = 8'h42;
    localparam logic [7:0] CH_LITTLE   = 8'h6C;
    localparam logic [7:0] CH_OBJ      = 8'h6F;
    localparam logic [7:0] CH_STR      = 8'h73;
    localparam logic [7:0] CH_SIG      = 8'h67;
    localparam logic [7:0] PROTO_VER   = 8'h01;

    localparam logic [7:0] LOCAL_PATH_LEN  = 8'd27;
    localparam logic [7:0] LOCAL_IFACE_LEN = 8'd26;

    // Reserved local object path, padded to a power of two.
    localparam logic [7:0] LOCAL_PATH [32] = '{
        8'h2F, 8'h6F, 8'h72, 8'h67, 8'h2F, 8'h66, 8'h72, 8'h65,
        8'h65, 8'h64, 8'h65, 8'h73, 8'h6B, 8'h74, 8'h6F, 8'h70,
        8'h2F, 8'h44, 8'h42, 8'h75, 8'h73, 8'h2F, 8'h4C, 8'h6F,
        8'h63, 8'h61, 8'h6C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Reserved local interface name, padded likewise.
    localparam logic [7:0] LOCAL_IFACE [32] = '{
        8'h6F, 8'h72, 8'h67, 8'h2E, 8'h66, 8'h72, 8'h65, 8'h65,
        8'h64, 8'h65, 8'h73, 8'h6B, 8'h74, 8'h6F, 8'h70, 8'h2E,
        8'h44, 8'h42, 8'h75, 8'h73, 8'h2E, 8'h4C, 8'h6F, 8'h63,
        8'h61, 8'h6C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        logic [POS_W-1:0] count;
        logic             too_long;
        logic [7:0]       endian_mark;
        logic [7:0]       msg_type;
        logic [7:0]       msg_flags;
        logic [7:0]       version;
        logic             big_endian;
        logic [31:0]      body_length;
        logic [31:0]      serial;
        logic [POS_W-1:0] array_end;
        logic [31:0]      reply_serial;
        logic [31:0]      unix_fds;
        logic [8:0]       seen;
        err_t             first_error;
        logic [1:0]       local_hits;
    } summary_t;

endpackage

// ----- rtl/dbv_front.sv -----
// Byte parser: fixed header and field array, one byte per cycle while the queue has room.
`timescale 1ns / 1ps

module dbv_front #(
    parameter int OFFSET_WIDTH = dbv_pkg::OFFSET_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        data_byte,
    input  logic              last,
    input  logic              queue_ready,
    output logic              in_stall,
    output logic              push,
    output dbv_pkg::summary_t summary
);

    localparam int PW = dbv_pkg::POS_W;

    logic                    accept;
    logic [OFFSET_WIDTH-1:0] pos_reg, pos_next;
    logic                    too_long_reg, too_long_next;
    dbv_pkg::phase_t         phase_reg, phase_next;
    logic                    endian_reg, endian_next;
    logic [7:0]              head0_reg, head0_next;
    logic [7:0]              type_reg, type_next;
    logic [7:0]              flags_reg, flags_next;
    logic [7:0]              version_reg, version_next;
    logic [PW-1:0]           array_end_reg, array_end_next;
    logic [PW-1:0]           next_pos_reg, next_pos_next;
    logic [31:0]             word_reg, word_next;
    logic [1:0]              wb_idx_reg, wb_idx_next;
    logic [31:0]             remaining_reg, remaining_next;
    logic [7:0]              field_reg, field_next;
    logic [7:0]              sig_char_reg, sig_char_next;
    logic [7:0]              sig_len_reg, sig_len_next;
    logic                    value_sig_reg, value_sig_next;
    logic [4:0]              lidx_reg, lidx_next;
    logic                    ltrack_reg, ltrack_next;
    logic [1:0]              lhits_reg, lhits_next;
    logic [31:0]             body_reg, body_next;
    logic [31:0]             serial_reg, serial_next;
    logic [31:0]             reply_reg, reply_next;
    logic [31:0]             fds_reg, fds_next;
    logic [8:0]              seen_reg, seen_next;
    dbv_pkg::err_t           ferr_reg, ferr_next;

    logic [PW-1:0] pos_ext, off, a8, a4;
    logic          bf_done, bf_bad, bs_bad, w4_bad, sl_bad, st_bad;
    logic [1:0]    widx;
    logic [31:0]   wbase, word_full;
    logic [8:0]    seen_mark;
    logic [7:0]    want;

    assign in_stall = !queue_ready;
    assign accept   = in_valid && queue_ready;
    assign push     = accept && last;

    assign pos_ext = PW'(pos_reg);
    assign off     = pos_ext + PW'(1);
    assign a8      = (off + PW'(7)) & ~PW'(7);
    assign a4      = (off + PW'(3)) & ~PW'(3);
    assign bf_done = off >= array_end_reg;
    assign bf_bad  = a8 >= array_end_reg;
    assign bs_bad  = (a4 + PW'(4)) >= array_end_reg;
    assign w4_bad  = (off + PW'(4)) > array_end_reg;
    assign sl_bad  = (off + PW'(data_byte) + PW'(1)) > array_end_reg;

    assign widx  = (phase_reg == dbv_pkg::PH_FIXED) ? pos_reg[1:0] : wb_idx_reg;
    assign wbase = (widx == 2'd0) ? '0 : word_reg;

    always_comb
    begin
        if (endian_reg)
            word_full = {wbase[23:0], data_byte};
        else
            word_full = wbase | (32'(data_byte) << {widx, 3'b000});
    end

    assign st_bad = (off + PW'(word_full) + PW'(1)) > array_end_reg;

    assign seen_mark = (field_reg >= dbv_pkg::FLD_PATH && field_reg <= dbv_pkg::FLD_UNIX_FDS)
                     ? (seen_reg | (9'(1) << (field_reg - 8'd1))) : seen_reg;
    assign want = (field_reg == dbv_pkg::FLD_PATH) ? dbv_pkg::LOCAL_PATH[lidx_reg]
                                                   : dbv_pkg::LOCAL_IFACE[lidx_reg];

    always_comb
    begin
        logic          do_fail;
        logic          do_bf;
        dbv_pkg::err_t fail_c;

        do_fail        = 1'b0;
        do_bf          = 1'b0;
        fail_c         = dbv_pkg::ERR_NONE;
        pos_next       = pos_reg;
        too_long_next  = too_long_reg;
        phase_next     = phase_reg;
        endian_next    = endian_reg;
        head0_next     = head0_reg;
        type_next      = type_reg;
        flags_next     = flags_reg;
        version_next   = version_reg;
        array_end_next = array_end_reg;
        next_pos_next  = next_pos_reg;
        word_next      = word_reg;
        wb_idx_next    = wb_idx_reg;
        remaining_next = remaining_reg;
        field_next     = field_reg;
        sig_char_next  = sig_char_reg;
        sig_len_next   = sig_len_reg;
        value_sig_next = value_sig_reg;
        lidx_next      = lidx_reg;
        ltrack_next    = ltrack_reg;
        lhits_next     = lhits_reg;
        body_next      = body_reg;
        serial_next    = serial_reg;
        reply_next     = reply_reg;
        fds_next       = fds_reg;
        seen_next      = seen_reg;
        ferr_next      = ferr_reg;

        if (!too_long_reg)
        begin
            if (phase_reg == dbv_pkg::PH_FIXED)
            begin
                if (pos_ext < PW'(4))
                begin
                    case (pos_reg[1:0])
                        2'd0:
                        begin
                            head0_next  = data_byte;
                            endian_next = (data_byte == dbv_pkg::CH_BIG);
                        end
                        2'd1: type_next    = data_byte;
                        2'd2: flags_next   = data_byte;
                        default: version_next = data_byte;
                    endcase
                end
                else
                begin
                    word_next = word_full;
                    if (pos_reg[1:0] == 2'd3)
                    begin
                        case (pos_reg[3:2])
                            2'd1: body_next   = word_full;
                            2'd2: serial_next = word_full;
                            2'd3:
                            begin
                                // Array length known: open the field walk at offset 16.
                                array_end_next = PW'(16) + PW'(word_full);
                                word_next      = '0;
                                if (word_full == '0)
                                    phase_next = dbv_pkg::PH_DONE;
                                else
                                begin
                                    phase_next    = dbv_pkg::PH_CODE;
                                    next_pos_next = PW'(16);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            else if (phase_reg != dbv_pkg::PH_DONE && phase_reg != dbv_pkg::PH_ERR &&
                     pos_ext >= next_pos_reg)
            begin
                next_pos_next = off;
                case (phase_reg)
                    dbv_pkg::PH_CODE:
                    begin
                        field_next = data_byte;
                        if (bf_done)
                        begin
                            do_fail = 1'b1;
                            fail_c  = dbv_pkg::ERR_BOUNDS;
                        end
                        else
                        begin
                            value_sig_next = 1'b0;
                            phase_next     = dbv_pkg::PH_SIGLEN;
                        end
                    end
                    dbv_pkg::PH_SIGLEN:
                    begin
                        sig_len_next  = data_byte;
                        sig_char_next = '0;
                        if (sl_bad)
                        begin
                            do_fail = 1'b1;
                            fail_c  = dbv_pkg::ERR_BOUNDS;
                        end
                        else
                        begin
                            remaining_next = 32'(data_byte);
                            phase_next = (data_byte == '0) ? dbv_pkg::PH_SIGNUL
                                                           : dbv_pkg::PH_SIGBODY;
                        end
                    end
                    dbv_pkg::PH_SIGBODY:
                    begin
                        if (data_byte == '0)
                        begin
                            do_fail = 1'b1;
                            fail_c  = dbv_pkg::ERR_STRING;
                        end
                        else
                        begin
                            if (remaining_reg == 32'(sig_len_reg))
                                sig_char_next = data_byte;
                            remaining_next = remaining_reg - 32'd1;
                            if (remaining_reg == 32'd1)
                                phase_next = dbv_pkg::PH_SIGNUL;
                        end
                    end
                    dbv_pkg::PH_SIGNUL:
                    begin
                        if (data_byte != '0)
                        begin
                            do_fail = 1'b1;
                            fail_c  = dbv_pkg::ERR_STRING;
                        end
                        else if (value_sig_reg)
                        begin
                            if (sig_len_reg == '0)
                            begin
                                do_fail = 1'b1;
                                fail_c  = dbv_pkg::ERR_STRING;
                            end
                            else
                            begin
                                seen_next = seen_mark;
                                do_bf     = 1'b1;
                            end
                        end
                        else
                        begin
                            // Variant signature done: pick the value parser by field code.
                            case (field_reg)
                                dbv_pkg::FLD_PATH, dbv_pkg::FLD_IFACE, dbv_pkg::FLD_MEMBER,
                                dbv_pkg::FLD_ERRNAME, dbv_pkg::FLD_DEST, dbv_pkg::FLD_SENDER:
                                begin
                                    if (sig_len_reg != 8'd1 ||
                                        sig_char_reg != ((field_reg == dbv_pkg::FLD_PATH)
                                                         ? dbv_pkg::CH_OBJ : dbv_pkg::CH_STR))
                                    begin
                                        do_fail = 1'b1;
                                        fail_c  = dbv_pkg::ERR_SIGNATURE;
                                    end
                                    else if (bs_bad)
                                    begin
                                        do_fail = 1'b1;
                                        fail_c  = dbv_pkg::ERR_BOUNDS;
                                    end
                                    else
                                    begin
                                        next_pos_next = a4;
                                        wb_idx_next   = '0;
                                        word_next     = '0;
                                        phase_next    = dbv_pkg::PH_STRLEN;
                                    end
                                end
                                dbv_pkg::FLD_SIGNATURE:
                                begin
                                    if (sig_len_reg != 8'd1 || sig_char_reg != dbv_pkg::CH_SIG)
                                    begin
                                        do_fail = 1'b1;
                                        fail_c  = dbv_pkg::ERR_SIGNATURE;
                                    end
                                    else if (bf_done)
                                    begin
                                        do_fail = 1'b1;
                                        fail_c  = dbv_pkg::ERR_BOUNDS;
                                    end
                                    else
                                    begin
                                        value_sig_next = 1'b1;
                                        phase_next     = dbv_pkg::PH_SIGLEN;
                                    end
                                end
                                dbv_pkg::FLD_REPLY, dbv_pkg::FLD_UNIX_FDS:
                                begin
                                    if (w4_bad)
                                    begin
                                        do_fail = 1'b1;
                                        fail_c  = dbv_pkg::ERR_BOUNDS;
                                    end
                                    else
                                    begin
                                        wb_idx_next = '0;
                                        word_next   = '0;
                                        phase_next  = dbv_pkg::PH_WORD;
                                    end
                                end
                                default:
                                begin
                                    do_fail = 1'b1;
                                    fail_c  = dbv_pkg::ERR_FIELD_CODE;
                                end
                            endcase
                        end
                    end
                    dbv_pkg::PH_STRLEN:
                    begin
                        word_next   = word_full;
                        wb_idx_next = wb_idx_reg + 2'd1;
                        if (wb_idx_reg == 2'd3)
                        begin
                            if (st_bad)
                            begin
                                do_fail = 1'b1;
                                fail_c  = dbv_pkg::ERR_BOUNDS;
                            end
                            else if (word_full == '0)
                            begin
                                do_fail = 1'b1;
                                fail_c  = dbv_pkg::ERR_STRING;
                            end
                            else
                            begin
                                remaining_next = word_full;
                                lidx_next      = '0;
                                ltrack_next    =
                                    (field_reg == dbv_pkg::FLD_PATH &&
                                     word_full == 32'(dbv_pkg::LOCAL_PATH_LEN)) ||
                                    (field_reg == dbv_pkg::FLD_IFACE &&
                                     word_full == 32'(dbv_pkg::LOCAL_IFACE_LEN));
                                phase_next     = dbv_pkg::PH_STRBODY;
                            end
                        end
                    end
                    dbv_pkg::PH_STRBODY:
                    begin
                        if (data_byte == '0)
                        begin
                            do_fail = 1'b1;
                            fail_c  = dbv_pkg::ERR_STRING;
                        end
                        else
                        begin
                            if (ltrack_reg)
                            begin
                                if (data_byte != want)
                                    ltrack_next = 1'b0;
                                lidx_next = lidx_reg + 5'd1;
                            end
                            remaining_next = remaining_reg - 32'd1;
                            if (remaining_reg == 32'd1)
                                phase_next = dbv_pkg::PH_STRNUL;
                        end
                    end
                    dbv_pkg::PH_STRNUL:
                    begin
                        if (data_byte != '0)
                        begin
                            do_fail = 1'b1;
                            fail_c  = dbv_pkg::ERR_STRING;
                        end
                        else
                        begin
                            seen_next = seen_mark;
                            if (field_reg == dbv_pkg::FLD_PATH)
                                lhits_next[0] = ltrack_reg;
                            if (field_reg == dbv_pkg::FLD_IFACE)
                                lhits_next[1] = ltrack_reg;
                            do_bf = 1'b1;
                        end
                    end
                    dbv_pkg::PH_WORD:
                    begin
                        word_next   = word_full;
                        wb_idx_next = wb_idx_reg + 2'd1;
                        if (wb_idx_reg == 2'd3)
                        begin
                            if (field_reg == dbv_pkg::FLD_REPLY)
                                reply_next = word_full;
                            else
                                fds_next = word_full;
                            seen_next = seen_mark;
                            do_bf     = 1'b1;
                        end
                    end
                    default: ;
                endcase

                // Advance to the next 8-aligned field struct, or finish the array.
                if (do_bf)
                begin
                    if (bf_done)
                        phase_next = dbv_pkg::PH_DONE;
                    else if (bf_bad)
                    begin
                        do_fail = 1'b1;
                        fail_c  = dbv_pkg::ERR_BOUNDS;
                    end
                    else
                    begin
                        next_pos_next = a8;
                        phase_next    = dbv_pkg::PH_CODE;
                    end
                end
                if (do_fail)
                begin
                    phase_next = dbv_pkg::PH_ERR;
                    ferr_next  = fail_c;
                end
            end
        end

        // Saturate the byte counter; past the top the message is overlong.
        if (pos_reg != '1)
            pos_next = pos_reg + OFFSET_WIDTH'(1);
        else
            too_long_next = 1'b1;
    end

    always_comb
    begin
        summary.count        = off;
        summary.too_long     = too_long_next;
        summary.endian_mark  = head0_next;
        summary.msg_type     = type_next;
        summary.msg_flags    = flags_next;
        summary.version      = version_next;
        summary.big_endian   = endian_next;
        summary.body_length  = body_next;
        summary.serial       = serial_next;
        summary.array_end    = array_end_next;
        summary.reply_serial = reply_next;
        summary.unix_fds     = fds_next;
        summary.seen         = seen_next;
        summary.first_error  = ferr_next;
        summary.local_hits   = lhits_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n || (accept && last))
        begin
            if (!rst_n)
                ;
            pos_reg       <= '0;
            too_long_reg  <= 1'b0;
            phase_reg     <= dbv_pkg::PH_FIXED;
            endian_reg    <= 1'b0;
            head0_reg     <= '0;
            type_reg      <= '0;
            flags_reg     <= '0;
            version_reg   <= '0;
            array_end_reg <= '0;
            next_pos_reg  <= '0;
            word_reg      <= '0;
            wb_idx_reg    <= '0;
            remaining_reg <= '0;
            field_reg     <= '0;
            sig_char_reg  <= '0;
            sig_len_reg   <= '0;
            value_sig_reg <= 1'b0;
            lidx_reg      <= '0;
            ltrack_reg    <= 1'b0;
            lhits_reg     <= '0;
            body_reg      <= '0;
            serial_reg    <= '0;
            reply_reg     <= '0;
            fds_reg       <= '0;
            seen_reg      <= '0;
            ferr_reg      <= dbv_pkg::ERR_NONE;
        end
        else if (accept)
        begin
            pos_reg       <= pos_next;
            too_long_reg  <= too_long_next;
            phase_reg     <= phase_next;
            endian_reg    <= endian_next;
            head0_reg     <= head0_next;
            type_reg      <= type_next;
            flags_reg     <= flags_next;
            version_reg   <= version_next;
            array_end_reg <= array_end_next;
            next_pos_reg  <= next_pos_next;
            word_reg      <= word_next;
            wb_idx_reg    <= wb_idx_next;
            remaining_reg <= remaining_next;
            field_reg     <= field_next;
            sig_char_reg  <= sig_char_next;
            sig_len_reg   <= sig_len_next;
            value_sig_reg <= value_sig_next;
            lidx_reg      <= lidx_next;
            ltrack_reg    <= ltrack_next;
            lhits_reg     <= lhits_next;
            body_reg      <= body_next;
            serial_reg    <= serial_next;
            reply_reg     <= reply_next;
            fds_reg       <= fds_next;
            seen_reg      <= seen_next;
            ferr_reg      <= ferr_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == dbv_pkg::PH_ERR) == (ferr_reg != dbv_pkg::ERR_NONE))
        else $error("error phase and first error code disagree");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == dbv_pkg::PH_ERR && !(accept && last)) |=> phase_reg == dbv_pkg::PH_ERR)
        else $error("error phase left before the end of the message");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (phase_reg == dbv_pkg::PH_FIXED && pos_reg == '0 && !too_long_reg))
        else $error("parser not back at the fixed header after the last byte");

endmodule

// ----- rtl/dbv_queue.sv -----
// Two-entry queue of finished header summaries between the parser and the checker.
`timescale 1ns / 1ps

module dbv_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dbv_pkg::summary_t wr_data,
    output logic              ready,
    input  logic              pop,
    output logic              rd_valid,
    output dbv_pkg::summary_t rd_data
);

    dbv_pkg::summary_t entry_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;

    assign ready    = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> count_reg != 2'd2)
        else $error("summary pushed into a full queue");

endmodule

// ----- rtl/dbv_back.sv -----
// Final checks on a header summary and the registered result stage.
`timescale 1ns / 1ps

module dbv_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_valid,
    input  dbv_pkg::summary_t rd_data,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              valid_res,
    output logic [3:0]        error_code,
    output logic [7:0]        msg_type,
    output logic [7:0]        msg_flags,
    output logic              big_endian,
    output logic [31:0]       body_length,
    output logic [31:0]       serial,
    output logic [31:0]       reply_serial,
    output logic              has_reply_serial,
    output logic [31:0]       unix_fds,
    output logic [8:0]        field_mask
);

    localparam int PW = dbv_pkg::POS_W;

    logic [PW-1:0]  hlen;
    dbv_pkg::err_t  err;
    logic [8:0]     s;
    logic           ok;

    logic           out_valid_reg;
    logic           valid_res_reg;
    logic [3:0]     error_code_reg;
    logic [7:0]     msg_type_reg, msg_flags_reg;
    logic           big_endian_reg, has_reply_reg;
    logic [31:0]    body_reg, serial_reg, reply_reg, fds_reg;
    logic [8:0]     mask_reg;

    assign s    = rd_data.seen;
    assign hlen = (rd_data.array_end + PW'(7)) & ~PW'(7);
    assign pop  = rd_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        err = dbv_pkg::ERR_NONE;
        if (rd_data.count < PW'(16))
            err = dbv_pkg::ERR_SHORT;
        else if (rd_data.version != dbv_pkg::PROTO_VER)
            err = dbv_pkg::ERR_VERSION;
        else if (rd_data.endian_mark != dbv_pkg::CH_BIG &&
                 rd_data.endian_mark != dbv_pkg::CH_LITTLE)
            err = dbv_pkg::ERR_ENDIAN;
        else if (rd_data.serial == '0)
            err = dbv_pkg::ERR_SERIAL;
        else if (rd_data.too_long || hlen > rd_data.count)
            err = dbv_pkg::ERR_OVERRUN;
        else if (rd_data.first_error != dbv_pkg::ERR_NONE)
            err = rd_data.first_error;
        else
        begin
            case (rd_data.msg_type)
                dbv_pkg::MT_CALL:
                    err = (s[0] && s[2]) ? dbv_pkg::ERR_NONE : dbv_pkg::ERR_REQUIRED;
                dbv_pkg::MT_RETURN:
                    err = s[4] ? dbv_pkg::ERR_NONE : dbv_pkg::ERR_REQUIRED;
                dbv_pkg::MT_ERROR:
                    err = (s[3] && s[4]) ? dbv_pkg::ERR_NONE : dbv_pkg::ERR_REQUIRED;
                dbv_pkg::MT_SIGNAL:
                begin
                    if (!(s[0] && s[1] && s[2]))
                        err = dbv_pkg::ERR_REQUIRED;
                    else if (rd_data.local_hits != '0)
                        err = dbv_pkg::ERR_LOCAL;
                end
                default:
                    err = dbv_pkg::ERR_TYPE;
            endcase
        end
    end

    assign ok = (err == dbv_pkg::ERR_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Zero every field but the error code on a rejected header.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            valid_res_reg  <= ok;
            error_code_reg <= err;
            msg_type_reg   <= ok ? rd_data.msg_type : '0;
            msg_flags_reg  <= ok ? rd_data.msg_flags : '0;
            big_endian_reg <= ok && rd_data.big_endian;
            body_reg       <= ok ? rd_data.body_length : '0;
            serial_reg     <= ok ? rd_data.serial : '0;
            reply_reg      <= ok ? rd_data.reply_serial : '0;
            has_reply_reg  <= ok && s[4];
            fds_reg        <= ok ? rd_data.unix_fds : '0;
            mask_reg       <= ok ? s : '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign valid_res        = valid_res_reg;
    assign error_code       = error_code_reg;
    assign msg_type         = msg_type_reg;
    assign msg_flags        = msg_flags_reg;
    assign big_endian       = big_endian_reg;
    assign body_length      = body_reg;
    assign serial           = serial_reg;
    assign reply_serial     = reply_reg;
    assign has_reply_serial = has_reply_reg;
    assign unix_fds         = fds_reg;
    assign field_mask       = mask_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !valid_res_reg) |->
            (body_reg == '0 && serial_reg == '0 && mask_reg == '0 &&
             error_code_reg != dbv_pkg::ERR_NONE))
        else $error("rejected header carries field data or no error code");

endmodule

// ----- rtl/dbus_header_validator.sv -----
// Message header validator: byte parser, summary queue and final check stage.
// Throughput: one byte per cycle; the input stalls only while two results wait unread.
// Result path: the summary enters the queue at the edge that takes the last byte,
// then the check and output register stage takes it once the output is free.
// Reset: rst_n clears the parser, queue and output valid asynchronously; no clearing pass.
`timescale 1ns / 1ps

module dbus_header_validator #(
    parameter int OFFSET_WIDTH = dbv_pkg::OFFSET_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        valid_res,
    output logic [3:0]  error_code,
    output logic [7:0]  msg_type,
    output logic [7:0]  msg_flags,
    output logic        big_endian,
    output logic [31:0] body_length,
    output logic [31:0] serial,
    output logic [31:0] reply_serial,
    output logic        has_reply_serial,
    output logic [31:0] unix_fds,
    output logic [8:0]  field_mask
);

    logic              queue_ready;
    logic              push;
    logic              pop;
    logic              rd_valid;
    dbv_pkg::summary_t wr_data;
    dbv_pkg::summary_t rd_data;

    dbv_front #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .data_byte   (data_byte),
        .last        (last),
        .queue_ready (queue_ready),
        .in_stall    (in_stall),
        .push        (push),
        .summary     (wr_data)
    );

    dbv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_data  (wr_data),
        .ready    (queue_ready),
        .pop      (pop),
        .rd_valid (rd_valid),
        .rd_data  (rd_data)
    );

    dbv_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .rd_valid         (rd_valid),
        .rd_data          (rd_data),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .valid_res        (valid_res),
        .error_code       (error_code),
        .msg_type         (msg_type),
        .msg_flags        (msg_flags),
        .big_endian       (big_endian),
        .body_length      (body_length),
        .serial           (serial),
        .reply_serial     (reply_serial),
        .has_reply_serial (has_reply_serial),
        .unix_fds         (unix_fds),
        .field_mask       (field_mask)
    );

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the message header validator.
`timescale 1ns / 1ps

module tb_top;
    import dbv_pkg::*;

    typedef struct {
        logic        ok;
        logic [3:0]  code;
        logic [7:0]  mtype;
        logic [7:0]  flags;
        logic        big;
        logic [31:0] body;
        logic [31:0] serial_no;
        logic [31:0] reply;
        logic        has_reply;
        logic [31:0] fds;
        logic [8:0]  mask;
    } verdict_t;

    typedef enum {
        K_CALL_LE, K_CALL_BE, K_RETURN, K_ERRMSG, K_SIGNAL, K_EXTREMES, K_ALLFIELDS,
        K_SHORT1, K_SHORT15, K_VERSION, K_ENDIAN, K_ALLFF, K_SERIAL0, K_OVERRUN,
        K_BOUNDS, K_FIELD0, K_FIELD_HI, K_BADSIG, K_EMPTYSTR, K_NULSTR, K_EMPTYSIG,
        K_REQUIRED, K_NOFIELDS, K_TYPE0, K_TYPE_FF, K_LOCALPATH, K_LOCALIFACE
    } msg_kind_t;

    typedef struct {
        msg_kind_t kind;
        bit        typed;
        err_t      code;
    } dir_row_t;

    dir_row_t dir_rows [27] = '{
        '{K_CALL_LE,   1'b0, ERR_NONE},
        '{K_CALL_BE,   1'b0, ERR_NONE},
        '{K_RETURN,    1'b0, ERR_NONE},
        '{K_ERRMSG,    1'b0, ERR_NONE},
        '{K_SIGNAL,    1'b0, ERR_NONE},
        '{K_EXTREMES,  1'b0, ERR_NONE},
        '{K_ALLFIELDS, 1'b0, ERR_NONE},
        '{K_SHORT1,    1'b1, ERR_SHORT},
        '{K_SHORT15,   1'b1, ERR_SHORT},
        '{K_VERSION,   1'b1, ERR_VERSION},
        '{K_ENDIAN,    1'b1, ERR_ENDIAN},
        '{K_ALLFF,     1'b1, ERR_VERSION},
        '{K_SERIAL0,   1'b1, ERR_SERIAL},
        '{K_OVERRUN,   1'b1, ERR_OVERRUN},
        '{K_BOUNDS,    1'b1, ERR_BOUNDS},
        '{K_FIELD0,    1'b1, ERR_FIELD_CODE},
        '{K_FIELD_HI,  1'b1, ERR_FIELD_CODE},
        '{K_BADSIG,    1'b1, ERR_SIGNATURE},
        '{K_EMPTYSTR,  1'b1, ERR_STRING},
        '{K_NULSTR,    1'b1, ERR_STRING},
        '{K_EMPTYSIG,  1'b1, ERR_STRING},
        '{K_REQUIRED,  1'b1, ERR_REQUIRED},
        '{K_NOFIELDS,  1'b1, ERR_REQUIRED},
        '{K_TYPE0,     1'b1, ERR_TYPE},
        '{K_TYPE_FF,   1'b1, ERR_TYPE},
        '{K_LOCALPATH, 1'b1, ERR_LOCAL},
        '{K_LOCALIFACE, 1'b1, ERR_LOCAL}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    logic        valid_res;
    logic [3:0]  error_code;
    logic [7:0]  msg_type;
    logic [7:0]  msg_flags;
    logic        big_endian;
    logic [31:0] body_length;
    logic [31:0] serial;
    logic [31:0] reply_serial;
    logic        has_reply_serial;
    logic [31:0] unix_fds;
    logic [8:0]  field_mask;

    dbus_header_validator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte), .last(last),
        .out_valid(out_valid), .out_stall(out_stall),
        .valid_res(valid_res), .error_code(error_code), .msg_type(msg_type),
        .msg_flags(msg_flags), .big_endian(big_endian), .body_length(body_length),
        .serial(serial), .reply_serial(reply_serial), .has_reply_serial(has_reply_serial),
        .unix_fds(unix_fds), .field_mask(field_mask)
    );

    verdict_t    expected_verdicts[$];
    bit          failed;
    bit          calm;
    int          stall_left;

    // Header parser state
    logic [63:0] hp_count;
    phase_t      hp_phase;
    logic        hp_big;
    logic [63:0] hp_aend;
    logic [63:0] hp_next;
    logic [31:0] hp_acc;
    logic [63:0] hp_rem;
    logic [7:0]  hp_field;
    logic [7:0]  hp_sig_first;
    logic [7:0]  hp_sig_len;
    logic        hp_value_sig;
    int          hp_midx;
    logic        hp_track;
    logic [1:0]  hp_hits;
    logic [31:0] hp_vals [5];
    logic [7:0]  hp_head [4];
    logic [8:0]  hp_seen;
    err_t        hp_first_err;

    // Message under construction
    logic [7:0]  msg[$];
    logic [7:0]  txt[$];
    bit          msg_be;

    always #4 clk = ~clk;

    function automatic void clear_parser();
        hp_count = 0; hp_phase = PH_FIXED; hp_big = 0; hp_aend = 0; hp_next = 0;
        hp_acc = 0; hp_rem = 0; hp_field = 0; hp_sig_first = 0; hp_sig_len = 0;
        hp_value_sig = 0; hp_midx = 0; hp_track = 0; hp_hits = 0; hp_seen = 0;
        hp_first_err = ERR_NONE;
        for (int i = 0; i < 5; i++) hp_vals[i] = 0;
        for (int i = 0; i < 4; i++) hp_head[i] = 0;
    endfunction

    function automatic void hp_fail(err_t c);
        if (hp_first_err == ERR_NONE) hp_first_err = c;
        hp_phase = PH_ERR;
    endfunction

    function automatic void open_field(logic [63:0] off);
        logic [63:0] a;
        if (off >= hp_aend) begin
            hp_phase = PH_DONE;
            return;
        end
        a = (off + 7) & ~64'd7;
        if (a >= hp_aend) hp_fail(ERR_BOUNDS);
        else begin
            hp_next = a;
            hp_phase = PH_CODE;
        end
    endfunction

    function automatic void open_sig(logic [63:0] off, logic is_value);
        if (off >= hp_aend) hp_fail(ERR_BOUNDS);
        else begin
            hp_value_sig = is_value;
            hp_next = off;
            hp_phase = PH_SIGLEN;
        end
    endfunction

    function automatic void open_word(logic [63:0] off, phase_t ph);
        hp_next = off;
        hp_rem = 4;
        hp_acc = 0;
        hp_phase = ph;
    endfunction

    function automatic void open_string(logic [63:0] off);
        logic [63:0] a;
        a = (off + 3) & ~64'd3;
        if (a + 4 >= hp_aend) hp_fail(ERR_BOUNDS);
        else open_word(a, PH_STRLEN);
    endfunction

    function automatic void check_signature(logic [63:0] off);
        case (hp_field)
            FLD_PATH:
                if (!(hp_sig_len == 1 && hp_sig_first == CH_OBJ)) hp_fail(ERR_SIGNATURE);
                else open_string(off);
            FLD_IFACE, FLD_MEMBER, FLD_ERRNAME, FLD_DEST, FLD_SENDER:
                if (!(hp_sig_len == 1 && hp_sig_first == CH_STR)) hp_fail(ERR_SIGNATURE);
                else open_string(off);
            FLD_SIGNATURE:
                if (!(hp_sig_len == 1 && hp_sig_first == CH_SIG)) hp_fail(ERR_SIGNATURE);
                else open_sig(off, 1'b1);
            FLD_REPLY, FLD_UNIX_FDS:
                if (off + 4 > hp_aend) hp_fail(ERR_BOUNDS);
                else open_word(off, PH_WORD);
            default:
                hp_fail(ERR_FIELD_CODE);
        endcase
    endfunction

    function automatic void shift_in(logic [7:0] b);
        int k;
        k = int'((64'd4 - hp_rem) & 64'd3);
        if (hp_big) hp_acc = {hp_acc[23:0], b};
        else hp_acc = hp_acc | (32'(b) << (8 * k));
        hp_rem = hp_rem - 1;
    endfunction

    function automatic void mark_field();
        if (hp_field >= 1 && hp_field <= 9) hp_seen[hp_field - 1] = 1'b1;
    endfunction

    function automatic void parse_header_byte(logic [63:0] pos, logic [7:0] b);
        logic [63:0] off;
        int          k;
        logic [7:0]  want;
        off = pos + 1;
        if (hp_phase == PH_FIXED) begin
            k = int'(pos[1:0]);
            if (pos < 4) begin
                hp_head[k] = b;
                if (pos == 0) hp_big = (b == CH_BIG);
                return;
            end
            if (k == 0) begin
                hp_acc = 0;
                hp_rem = 4;
            end
            shift_in(b);
            if (k == 3) hp_vals[(pos >> 2) - 1] = hp_acc;
            if (pos == 15) begin
                hp_aend = 64'd16 + hp_vals[2];
                hp_acc = 0;
                hp_rem = 0;
                open_field(16);
            end
            return;
        end
        if (hp_phase == PH_DONE || hp_phase == PH_ERR || pos < hp_next) return;
        hp_next = off;
        case (hp_phase)
            PH_CODE: begin
                hp_field = b;
                open_sig(off, 1'b0);
            end
            PH_SIGLEN: begin
                hp_sig_len = b;
                hp_sig_first = 0;
                if (off + b + 1 > hp_aend) hp_fail(ERR_BOUNDS);
                else begin
                    hp_rem = b;
                    hp_phase = (b == 0) ? PH_SIGNUL : PH_SIGBODY;
                end
            end
            PH_SIGBODY: begin
                if (b == 0) hp_fail(ERR_STRING);
                else begin
                    if (hp_rem == hp_sig_len) hp_sig_first = b;
                    hp_rem = hp_rem - 1;
                    if (hp_rem == 0) hp_phase = PH_SIGNUL;
                end
            end
            PH_SIGNUL: begin
                if (b != 0) hp_fail(ERR_STRING);
                else if (!hp_value_sig) check_signature(off);
                else if (hp_sig_len == 0) hp_fail(ERR_STRING);
                else begin
                    mark_field();
                    open_field(off);
                end
            end
            PH_STRLEN: begin
                shift_in(b);
                if (hp_rem == 0) begin
                    if (off + hp_acc + 1 > hp_aend) hp_fail(ERR_BOUNDS);
                    else if (hp_acc == 0) hp_fail(ERR_STRING);
                    else begin
                        hp_rem = hp_acc;
                        hp_midx = 0;
                        hp_track = (hp_field == FLD_PATH && hp_acc == 27) ||
                                   (hp_field == FLD_IFACE && hp_acc == 26);
                        hp_phase = PH_STRBODY;
                    end
                end
            end
            PH_STRBODY: begin
                if (b == 0) hp_fail(ERR_STRING);
                else begin
                    if (hp_track) begin
                        want = (hp_field == FLD_PATH) ? LOCAL_PATH[hp_midx % 27]
                                                      : LOCAL_IFACE[hp_midx % 26];
                        if (b != want) hp_track = 0;
                        hp_midx = (hp_midx + 1) & 63;
                    end
                    hp_rem = hp_rem - 1;
                    if (hp_rem == 0) hp_phase = PH_STRNUL;
                end
            end
            PH_STRNUL: begin
                if (b != 0) hp_fail(ERR_STRING);
                else begin
                    mark_field();
                    if (hp_field == FLD_PATH) hp_hits[0] = hp_track;
                    if (hp_field == FLD_IFACE) hp_hits[1] = hp_track;
                    open_field(off);
                end
            end
            PH_WORD: begin
                shift_in(b);
                if (hp_rem == 0) begin
                    hp_vals[hp_field == FLD_REPLY ? 3 : 4] = hp_acc;
                    mark_field();
                    open_field(off);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic verdict_t header_verdict(logic [63:0] count);
        verdict_t    v;
        logic [63:0] hlen;
        err_t        e;
        hlen = (hp_aend + 7) & ~64'd7;
        v = '{default: 0};
        if (count < 16) e = ERR_SHORT;
        else if (hp_head[3] != PROTO_VER) e = ERR_VERSION;
        else if (hp_head[0] != CH_BIG && hp_head[0] != CH_LITTLE) e = ERR_ENDIAN;
        else if (hp_vals[1] == 0) e = ERR_SERIAL;
        else if (hlen > count) e = ERR_OVERRUN;
        else if (hp_first_err != ERR_NONE) e = hp_first_err;
        else begin
            case (hp_head[1])
                MT_CALL:   e = (hp_seen[0] && hp_seen[2]) ? ERR_NONE : ERR_REQUIRED;
                MT_RETURN: e = hp_seen[4] ? ERR_NONE : ERR_REQUIRED;
                MT_ERROR:  e = (hp_seen[3] && hp_seen[4]) ? ERR_NONE : ERR_REQUIRED;
                MT_SIGNAL:
                    if (!(hp_seen[0] && hp_seen[1] && hp_seen[2])) e = ERR_REQUIRED;
                    else e = (hp_hits != 0) ? ERR_LOCAL : ERR_NONE;
                default:   e = ERR_TYPE;
            endcase
        end
        v.code = e;
        if (e == ERR_NONE) begin
            v.ok = 1;
            v.mtype = hp_head[1];
            v.flags = hp_head[2];
            v.big = hp_big;
            v.body = hp_vals[0];
            v.serial_no = hp_vals[1];
            v.reply = hp_vals[3];
            v.has_reply = hp_seen[4];
            v.fds = hp_vals[4];
            v.mask = hp_seen;
        end
        return v;
    endfunction

    // ---- message construction ----
    function automatic void put_word(logic [31:0] v);
        for (int i = 0; i < 4; i++) msg.push_back(msg_be ? v[31 - 8 * i -: 8] : v[8 * i +: 8]);
    endfunction

    function automatic void start_msg(bit be, logic [7:0] mt, logic [7:0] fl,
                                      logic [31:0] body, logic [31:0] ser);
        msg.delete();
        msg_be = be;
        msg.push_back(be ? CH_BIG : CH_LITTLE);
        msg.push_back(mt);
        msg.push_back(fl);
        msg.push_back(PROTO_VER);
        put_word(body);
        put_word(ser);
        put_word(0);
    endfunction

    function automatic void pad_to(int n);
        while (msg.size() % n != 0) msg.push_back(8'h00);
    endfunction

    function automatic void rand_text(int n);
        txt.delete();
        repeat (n) txt.push_back(8'($urandom_range(1, 255)));
    endfunction

    function automatic void local_text(bit iface);
        txt.delete();
        for (int i = 0; i < (iface ? LOCAL_IFACE_LEN : LOCAL_PATH_LEN); i++)
            txt.push_back(iface ? LOCAL_IFACE[i] : LOCAL_PATH[i]);
    endfunction

    function automatic void add_text_field(logic [7:0] code, logic [7:0] sigc);
        pad_to(8);
        msg.push_back(code);
        msg.push_back(8'd1);
        msg.push_back(sigc);
        msg.push_back(8'h00);
        put_word(txt.size());
        foreach (txt[i]) msg.push_back(txt[i]);
        msg.push_back(8'h00);
    endfunction

    function automatic void add_rand_field(logic [7:0] code, logic [7:0] sigc, int n);
        rand_text(n);
        add_text_field(code, sigc);
    endfunction

    function automatic void add_word_field(logic [7:0] code, logic [31:0] v);
        pad_to(8);
        msg.push_back(code);
        msg.push_back(8'd1);
        msg.push_back(8'h75);
        msg.push_back(8'h00);
        put_word(v);
    endfunction

    function automatic void add_sig_field();
        pad_to(8);
        msg.push_back(FLD_SIGNATURE);
        msg.push_back(8'd1);
        msg.push_back(CH_SIG);
        msg.push_back(8'h00);
        msg.push_back(8'(txt.size()));
        foreach (txt[i]) msg.push_back(txt[i]);
        msg.push_back(8'h00);
    endfunction

    function automatic void set_array_len(logic [31:0] n);
        for (int i = 0; i < 4; i++) msg[12 + i] = msg_be ? n[31 - 8 * i -: 8] : n[8 * i +: 8];
    endfunction

    function automatic void close_msg(int body_bytes);
        set_array_len(msg.size() - 16);
        pad_to(8);
        repeat (body_bytes) msg.push_back(8'($urandom));
    endfunction

    function automatic void build_directed(msg_kind_t kind);
        logic [7:0] mt;
        mt = (kind == K_TYPE0) ? 8'd0 : (kind == K_TYPE_FF) ? 8'hFF : MT_CALL;
        case (kind)
            K_RETURN: begin
                start_msg(0, MT_RETURN, 8'h00, 0, 32'd2);
                add_word_field(FLD_REPLY, 32'd7);
                close_msg(0);
            end
            K_ERRMSG: begin
                start_msg(1, MT_ERROR, 8'h01, 4, 32'd3);
                add_rand_field(FLD_ERRNAME, CH_STR, 9);
                add_word_field(FLD_REPLY, 32'h12345678);
                close_msg(4);
            end
            K_SIGNAL, K_LOCALPATH, K_LOCALIFACE: begin
                start_msg(1, MT_SIGNAL, 8'h00, 0, 32'd9);
                if (kind == K_LOCALPATH) local_text(0);
                else rand_text(6);
                add_text_field(FLD_PATH, CH_OBJ);
                if (kind == K_LOCALIFACE) local_text(1);
                else rand_text(7);
                add_text_field(FLD_IFACE, CH_STR);
                add_rand_field(FLD_MEMBER, CH_STR, 3);
                close_msg(0);
            end
            K_EXTREMES: begin
                start_msg(1, MT_RETURN, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                add_word_field(FLD_REPLY, 32'hFFFF_FFFF);
                add_word_field(FLD_UNIX_FDS, 32'hFFFF_FFFF);
                close_msg(8);
            end
            K_ALLFIELDS: begin
                start_msg(0, MT_CALL, 8'h02, 16, 32'd77);
                add_rand_field(FLD_PATH, CH_OBJ, 5);
                add_rand_field(FLD_IFACE, CH_STR, 8);
                add_rand_field(FLD_MEMBER, CH_STR, 4);
                add_rand_field(FLD_ERRNAME, CH_STR, 2);
                add_word_field(FLD_REPLY, 32'd5);
                add_rand_field(FLD_DEST, CH_STR, 11);
                add_rand_field(FLD_SENDER, CH_STR, 1);
                rand_text(2);
                add_sig_field();
                add_word_field(FLD_UNIX_FDS, 32'd3);
                close_msg(16);
            end
            K_SHORT1: begin
                msg.delete();
                msg.push_back(CH_LITTLE);
            end
            K_ALLFF: begin
                msg.delete();
                repeat (24) msg.push_back(8'hFF);
            end
            K_NOFIELDS: begin
                start_msg(0, MT_RETURN, 8'h00, 0, 32'd1);
                close_msg(0);
            end
            K_EMPTYSIG: begin
                start_msg(0, MT_CALL, 8'h00, 0, 32'd1);
                txt.delete();
                add_sig_field();
                close_msg(0);
            end
            K_REQUIRED: begin
                start_msg(1, MT_CALL, 8'h00, 0, 32'd1);
                add_rand_field(FLD_PATH, CH_OBJ, 4);
                close_msg(0);
            end
            default: begin
                start_msg(kind == K_CALL_BE, mt, 8'h00, 0,
                          (kind == K_SERIAL0) ? 32'd0 : 32'd1);
                if (kind == K_BADSIG) add_rand_field(FLD_PATH, CH_STR, 5);
                else if (kind == K_FIELD0) add_rand_field(8'd0, CH_STR, 5);
                else if (kind == K_FIELD_HI) add_rand_field(8'd200, CH_STR, 5);
                else add_rand_field(FLD_PATH, CH_OBJ, 5);
                if (kind == K_EMPTYSTR) txt.delete();
                else rand_text(4);
                if (kind == K_NULSTR) txt[2] = 8'h00;
                add_text_field(FLD_MEMBER, CH_STR);
                close_msg(kind == K_CALL_BE ? 3 : 0);
                case (kind)
                    K_SHORT15: while (msg.size() > 15) void'(msg.pop_back());
                    K_VERSION: msg[3] = 8'd2;
                    K_ENDIAN:  msg[0] = 8'h78;
                    K_OVERRUN: set_array_len(32'hFFFF_FFFF);
                    // cut the array inside the path string
                    K_BOUNDS:  set_array_len(32'd10);
                    default: ;
                endcase
            end
        endcase
    endfunction

    function automatic void build_random();
        int         order[$];
        int         j;
        int         tmp;
        int         r;
        logic [7:0] mt;
        logic [8:0] need;
        mt = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 4));
        case (mt)
            MT_CALL:   need = 9'b000000101;
            MT_RETURN: need = 9'b000010000;
            MT_ERROR:  need = 9'b000011000;
            MT_SIGNAL: need = 9'b000000111;
            default:   need = 9'b0;
        endcase
        start_msg($urandom_range(0, 1), mt, 8'($urandom),
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 64),
                  ($urandom_range(0, 30) == 0) ? 32'd0 : $urandom);
        for (int c = 1; c <= 9; c++)
            if (need[c - 1] ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 3) == 0))
                order.push_back(c);
        if (order.size() > 0 && $urandom_range(0, 7) == 0)
            order.push_back(order[$urandom_range(0, order.size() - 1)]);
        for (int i = order.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[i]) begin
            case (8'(order[i]))
                FLD_REPLY, FLD_UNIX_FDS:
                    add_word_field(8'(order[i]),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom);
                FLD_SIGNATURE: begin
                    rand_text(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4));
                    add_sig_field();
                end
                FLD_PATH, FLD_IFACE: begin
                    if ($urandom_range(0, 3) == 0) begin
                        local_text(order[i] == FLD_IFACE);
                        // near miss on the reserved name
                        if ($urandom_range(0, 2) == 0)
                            txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(1, 255));
                    end
                    else rand_text($urandom_range(1, 12));
                    add_text_field(8'(order[i]), (order[i] == FLD_PATH) ? CH_OBJ : CH_STR);
                end
                default: add_rand_field(8'(order[i]), CH_STR, $urandom_range(1, 12));
            endcase
        end
        close_msg($urandom_range(0, 12));
        r = $urandom_range(0, 19);
        if (r == 0) msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
        else if (r == 1) begin
            tmp = $urandom_range(1, msg.size());
            while (msg.size() > tmp) void'(msg.pop_back());
        end
        else if (r == 2) msg[$urandom_range(0, 15)] ^= 8'(1 << $urandom_range(0, 7));
        else if (r == 3) begin
            msg.delete();
            repeat ($urandom_range(1, 40)) msg.push_back(8'($urandom));
        end
    endfunction

    // ---- driving ----
    task automatic send_msg(bit typed, err_t code);
        verdict_t v;
        for (int i = 0; i < msg.size(); i++) begin
            if (!calm && $urandom_range(0, 7) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            in_valid <= 1'b1;
            data_byte <= msg[i];
            last <= (i == msg.size() - 1);
            do @(posedge clk); while (in_stall);
            parse_header_byte(hp_count, msg[i]);
            hp_count = hp_count + 1;
            if (i == msg.size() - 1) begin
                v = header_verdict(hp_count);
                if (typed) begin
                    v = '{default: 0};
                    v.code = code;
                end
                expected_verdicts.push_back(v);
                clear_parser();
            end
        end
    endtask

    function automatic void compare_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            failed = 1;
        end
    endfunction

    always @(posedge clk) begin
        verdict_t e;
        if (out_valid === 1'b1 && !out_stall) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual error_code %0h",
                         $time, error_code);
                failed = 1;
            end
            else begin
                e = expected_verdicts.pop_front();
                compare_field("valid_res", e.ok, valid_res);
                compare_field("error_code", e.code, error_code);
                compare_field("msg_type", e.mtype, msg_type);
                compare_field("msg_flags", e.flags, msg_flags);
                compare_field("big_endian", e.big, big_endian);
                compare_field("body_length", e.body, body_length);
                compare_field("serial", e.serial_no, serial);
                compare_field("reply_serial", e.reply, reply_serial);
                compare_field("has_reply_serial", e.has_reply, has_reply_serial);
                compare_field("unix_fds", e.fds, unix_fds);
                compare_field("field_mask", e.mask, field_mask);
            end
        end
        if (calm) out_stall <= 1'b0;
        else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 16);
        end
    end

    initial begin
        int sent_bytes;
        int random_msgs;
        int guard;
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        data_byte = 0;
        last = 0;
        out_stall = 0;
        failed = 0;
        calm = 0;
        stall_left = 0;
        sent_bytes = 0;
        random_msgs = 0;
        clear_parser();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i]) begin
            build_directed(dir_rows[i].kind);
            send_msg(dir_rows[i].typed, dir_rows[i].code);
        end
        while (sent_bytes < 1500 || random_msgs < 60) begin
            build_random();
            sent_bytes += msg.size();
            random_msgs++;
            send_msg(1'b0, ERR_NONE);
        end
        // finish at full rate on both sides
        calm = 1;
        repeat (10) begin
            build_random();
            send_msg(1'b0, ERR_NONE);
        end
        in_valid <= 1'b0;
        last <= 1'b0;
        guard = 0;
        while (expected_verdicts.size() != 0 && guard < 10000) begin
            @(posedge clk);
            guard++;
        end
        repeat (16) @(posedge clk);
        if (failed || expected_verdicts.size() != 0) $display("simulation failed");
        else $display("simulation ok");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
